>>> hdl/glmcd_pkg.sv
// Shared constants, types and the control bundle of the gap-limited min-cost chain.
package glmcd_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SCORE_BITS = 16;
  localparam int GAP_BITS   = 7;
  localparam int IDX_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [GAP_BITS-1:0]   gap_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  localparam score_t SCORE_MAX = {SCORE_BITS{1'b1}};
  localparam gap_t   GAP_RESET = gap_t'(1);

  typedef struct packed {
    logic   shift;
    score_t new_score;
  } chain_ctl_t;

endpackage

>>> hdl/glmcd_cell.sv
// One window cell: running minimum of the newest scores, fed by its left neighbor.
module glmcd_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  glmcd_pkg::chain_ctl_t ctl,
  input  glmcd_pkg::score_t     left,
  input  logic                  tap_en,
  output glmcd_pkg::score_t     run_min,
  output glmcd_pkg::score_t     tap
);

  glmcd_pkg::score_t run_min_next;

  always_comb begin
    run_min_next = (left < ctl.new_score) ? left : ctl.new_score;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= glmcd_pkg::SCORE_MAX;
    end else if (ctl.shift) begin
      run_min <= run_min_next;
    end
  end

  assign tap = tap_en ? run_min : '0;

endmodule

>>> hdl/glmcd_chain.sv
// Row of window cells and the tap select that yields the look-back minimum.
module glmcd_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  glmcd_pkg::chain_ctl_t ctl,
  input  glmcd_pkg::idx_t       gap_idx,
  output glmcd_pkg::score_t     window_min
);

  glmcd_pkg::score_t run_min [glmcd_pkg::WINDOW_MAX];
  glmcd_pkg::score_t tap     [glmcd_pkg::WINDOW_MAX];

  for (genvar k = 0; k < glmcd_pkg::WINDOW_MAX; k++) begin : g_cell
    glmcd_pkg::score_t left;
    logic              tap_en;

    if (k == 0) begin : g_head
      assign left = glmcd_pkg::SCORE_MAX;
    end else begin : g_body
      assign left = run_min[k-1];
    end

    assign tap_en = (gap_idx == glmcd_pkg::idx_t'(k));

    glmcd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .left    (left),
      .tap_en  (tap_en),
      .run_min (run_min[k]),
      .tap     (tap[k])
    );
  end

  always_comb begin
    window_min = '0;
    for (int k = 0; k < glmcd_pkg::WINDOW_MAX; k++) begin
      window_min = window_min | tap[k];
    end
  end

endmodule

>>> hdl/gap_limited_min_cost_dp.sv
// Top level: gap-limited minimum-cost recurrence over a stream of row positions.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in       | sink      | in_valid / in_stall  | present_bit, first_in_row
//   out      | source    | out_valid / out_stall| score
//   cfg      | sink      | cfg_we               | cfg_wdata (max_gap)
//
// One beat per cycle while in_stall is low: the score of a beat appears in the
// output register in the cycle after acceptance. Cell k holds the minimum of
// the newest k+1 scores, so the look-back minimum is a single tap read; the tap
// select, the increment and each cell's compare set the cycle time.
// Reset (synchronous) sets every cell to unreachable and max_gap to 1.
// in_stall rises only while a score waits in the output register under stall.
module gap_limited_min_cost_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [glmcd_pkg::GAP_BITS-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       present_bit,
  input  logic                       first_in_row,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [glmcd_pkg::SCORE_BITS-1:0] score
);

  glmcd_pkg::gap_t       max_gap;
  glmcd_pkg::idx_t       gap_idx;
  glmcd_pkg::score_t     window_min;
  glmcd_pkg::score_t     score_next;
  glmcd_pkg::chain_ctl_t ctl;
  logic                  in_accept;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    if (max_gap == '0) begin
      gap_idx = '0;
    end else if (32'(max_gap) >= 32'(glmcd_pkg::WINDOW_MAX)) begin
      gap_idx = glmcd_pkg::idx_t'(glmcd_pkg::WINDOW_MAX - 1);
    end else begin
      gap_idx = glmcd_pkg::idx_t'(max_gap - glmcd_pkg::gap_t'(1));
    end
  end

  always_comb begin
    if (first_in_row) begin
      score_next = '0;
    end else if (!present_bit && (window_min != glmcd_pkg::SCORE_MAX)) begin
      score_next = window_min + glmcd_pkg::score_t'(1);
    end else begin
      score_next = window_min;
    end
    ctl.shift     = in_accept;
    ctl.new_score = score_next;
  end

  glmcd_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .gap_idx    (gap_idx),
    .window_min (window_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap   <= glmcd_pkg::GAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap <= cfg_wdata;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      score <= score_next;
    end
  end

  a_first_scores_zero: assert property (@(posedge clk) disable iff (rst)
    in_accept && first_in_row |=> out_valid && (score == '0))
    else $error("first beat of a row did not score zero");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat left no score in the output register");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output register valid after reset");

  a_present_no_growth: assert property (@(posedge clk) disable iff (rst)
    in_accept && !first_in_row && present_bit |=> score == $past(window_min))
    else $error("present position changed the window minimum");

endmodule
